// ----- src/bvrs_pkg.sv -----
package bvrs_pkg;

  localparam int MaxBits   = 4096;
  localparam int BlockBits = 8;
  localparam int SuperBits = 64;

  localparam int CntW     = $clog2(MaxBits) + 1;
  localparam int PosW     = $clog2(MaxBits);
  localparam int BlkOffW  = $clog2(BlockBits);
  localparam int SbOffW   = $clog2(SuperBits);
  localparam int NumBlock = MaxBits / BlockBits;
  localparam int NumSuper = MaxBits / SuperBits;
  localparam int BlkCntW  = $clog2(SuperBits);
  localparam int FuncW    = 3;

  typedef enum logic [FuncW-1:0] {
    FN_CLEAR   = 3'd0,
    FN_APPEND  = 3'd1,
    FN_RANK1   = 3'd2,
    FN_RANK0   = 3'd3,
    FN_SELECT1 = 3'd4,
    FN_SELECT0 = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    RT_DIRECT,
    RT_RANK,
    RT_SELECT
  } route_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK_RD,
    ST_RANK_EV,
    ST_SEL_RD,
    ST_SEL_EV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic rank_eval;
    logic sel_eval;
    logic sel_finish;
  } cmd_t;

  typedef struct packed {
    route_e route;
    logic   search_done;
  } status_t;

endpackage

// ----- src/bitvector_rank_select.sv -----
// Rank/select bit vector of up to 4096 bits with a superblock and block
// one-count directory in on-chip memories. A request is taken when start_i is
// high and busy_o is low; its single result appears for exactly one cycle
// with done_o high and cannot be held off, so the receiver must capture it
// then. Clear, append, unknown function codes, requests that fail their range
// checks and selects with too few matching bits give their result in the
// cycle after acceptance. Rank does a registered read of the directory and
// bit memories followed by one add-and-mask step. Select is a binary search
// in which each probe is a read through the same memory read port followed
// by an evaluation step; no new request is taken until the result is given.
module bitvector_rank_select import bvrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [FuncW-1:0] func_i,
  input  logic             bit_value_i,
  input  logic [CntW-1:0]  query_value_i,
  output logic             done_o,
  output logic [CntW-1:0]  answer_o,
  output logic             found_o,
  output logic             error_o
);

  cmd_t    cmd;
  status_t status;

  bvrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  bvrs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (func_i),
    .bit_value_i   (bit_value_i),
    .query_value_i (query_value_i),
    .answer_o      (answer_o),
    .found_o       (found_o),
    .error_o       (error_o)
  );

endmodule

// ----- src/bvrs_ctrl.sv -----
module bvrs_ctrl import bvrs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (status_i.route)
            RT_RANK:   state_d = ST_RANK_RD;
            RT_SELECT: state_d = ST_SEL_RD;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_RANK_RD: state_d = ST_RANK_EV;
      ST_RANK_EV: state_d = ST_RESP;
      ST_SEL_RD: begin
        if (status_i.search_done) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_SEL_EV;
        end
      end
      ST_SEL_EV: state_d = ST_SEL_RD;
      ST_RESP:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      ST_RANK_RD: cmd_o.rd = 1'b1;
      ST_RANK_EV: cmd_o.rank_eval = 1'b1;
      ST_SEL_RD: begin
        cmd_o.sel_finish = status_i.search_done;
        cmd_o.rd         = !status_i.search_done;
      end
      ST_SEL_EV: cmd_o.sel_eval = 1'b1;
      ST_RESP:   done_o = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("Controller did not return to idle after a response.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.accept, cmd_o.rd, cmd_o.rank_eval, cmd_o.sel_eval,
                cmd_o.sel_finish, done_o}) <= 1)
    else $error("Controller issued more than one command in a cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> (cmd_o.rank_eval || cmd_o.sel_eval))
    else $error("Memory read was not followed by an evaluation.");

endmodule

// ----- src/bvrs_dpath.sv -----
module bvrs_dpath import bvrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic [FuncW-1:0] func_i,
  input  logic             bit_value_i,
  input  logic [CntW-1:0]  query_value_i,
  output logic [CntW-1:0]  answer_o,
  output logic             found_o,
  output logic             error_o
);

  logic [CntW-1:0]    len_q, len_d;
  logic [CntW-1:0]    total_q, total_d;
  logic [BlkCntW-1:0] ones_sb_q, ones_sb_d;

  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, k_q, k_d, x_q;
  logic            zeros_q, zeros_d, is_sel_q, is_sel_d;
  logic [CntW-1:0] answer_q, answer_d;
  logic            found_q, found_d, error_q, error_d;

  logic [CntW-1:0]      sb_mem   [NumSuper];
  logic [BlkCntW-1:0]   blkc_mem [NumBlock];
  logic [BlockBits-1:0] bits_mem [NumBlock];

  logic [CntW-1:0]      sb_rd_q;
  logic [BlkCntW-1:0]   blkc_rd_q;
  logic [BlockBits-1:0] bits_rd_q;

  logic [PosW-1:0]        wr_pos, rd_pos;
  logic [CntW-1:0]        rd_x, mid, target, ones_cnt, rank_val;
  logic [CntW:0]          mid_sum;
  logic [BlkOffW:0]       pop;
  logic                   wr_en, sb_start, full;
  logic [BlkCntW-1:0]     blk_cnt_wr;

  assign full       = (len_q >= CntW'(MaxBits));
  assign wr_pos     = len_q[PosW-1:0];
  assign sb_start   = (wr_pos[SbOffW-1:0] == '0);
  assign blk_cnt_wr = sb_start ? '0 : ones_sb_q;
  assign wr_en      = cmd_i.accept && (func_i == FN_APPEND) && !full;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CntW:1];
  assign rd_x    = is_sel_q ? mid : k_q;
  assign rd_pos  = rd_x[PosW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bits_mem[wr_pos[PosW-1:BlkOffW]][wr_pos[BlkOffW-1:0]] <= bit_value_i;
      if (wr_pos[BlkOffW-1:0] == '0) begin
        blkc_mem[wr_pos[PosW-1:BlkOffW]] <= blk_cnt_wr;
      end
      if (sb_start) begin
        sb_mem[wr_pos[PosW-1:SbOffW]] <= total_q;
      end
    end
    if (cmd_i.rd) begin
      sb_rd_q   <= sb_mem[rd_pos[PosW-1:SbOffW]];
      blkc_rd_q <= blkc_mem[rd_pos[PosW-1:BlkOffW]];
      bits_rd_q <= bits_mem[rd_pos[PosW-1:BlkOffW]];
      x_q       <= rd_x;
    end
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < BlockBits; i++) begin
      if (i < int'(x_q[BlkOffW-1:0])) begin
        pop = pop + (BlkOffW+1)'(bits_rd_q[i]);
      end
    end
    if (x_q >= len_q) begin
      ones_cnt = total_q;
    end else begin
      ones_cnt = sb_rd_q + CntW'(blkc_rd_q) + CntW'(pop);
    end
    rank_val = zeros_q ? (x_q - ones_cnt) : ones_cnt;
  end

  always_comb begin
    target = (func_i == FN_SELECT0) ? (len_q - total_q) : total_q;
    status_o.search_done = (lo_q >= hi_q);
    unique case (func_i) inside
      FN_RANK1, FN_RANK0: begin
        status_o.route = (query_value_i > len_q) ? RT_DIRECT : RT_RANK;
      end
      FN_SELECT1, FN_SELECT0: begin
        if (query_value_i == '0 || query_value_i > len_q || target < query_value_i) begin
          status_o.route = RT_DIRECT;
        end else begin
          status_o.route = RT_SELECT;
        end
      end
      default: status_o.route = RT_DIRECT;
    endcase
  end

  always_comb begin
    len_d    = len_q;
    total_d  = total_q;
    ones_sb_d = ones_sb_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    k_d      = k_q;
    zeros_d  = zeros_q;
    is_sel_d = is_sel_q;
    answer_d = answer_q;
    found_d  = found_q;
    error_d  = error_q;

    if (cmd_i.accept) begin
      answer_d = '0;
      found_d  = 1'b0;
      error_d  = 1'b0;
      k_d      = query_value_i;
      lo_d     = CntW'(1);
      hi_d     = len_q;
      zeros_d  = (func_i == FN_RANK0) || (func_i == FN_SELECT0);
      is_sel_d = (func_i == FN_SELECT1) || (func_i == FN_SELECT0);
      unique case (func_i) inside
        FN_CLEAR: begin
          len_d     = '0;
          total_d   = '0;
          ones_sb_d = '0;
        end
        FN_APPEND: begin
          if (full) begin
            error_d  = 1'b1;
            answer_d = len_q;
          end else begin
            len_d     = len_q + CntW'(1);
            answer_d  = len_q + CntW'(1);
            total_d   = total_q + CntW'(bit_value_i);
            ones_sb_d = blk_cnt_wr + BlkCntW'(bit_value_i);
          end
        end
        FN_RANK1, FN_RANK0: begin
          error_d = (query_value_i > len_q);
        end
        FN_SELECT1, FN_SELECT0: begin
          error_d = (query_value_i == '0) || (query_value_i > len_q);
        end
        default: error_d = 1'b1;
      endcase
    end

    if (cmd_i.rank_eval) begin
      answer_d = rank_val;
    end

    if (cmd_i.sel_eval) begin
      if (rank_val >= k_q) begin
        hi_d = x_q;
      end else begin
        lo_d = x_q + CntW'(1);
      end
    end

    if (cmd_i.sel_finish) begin
      answer_d = lo_q;
      found_d  = 1'b1;
      error_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      total_q   <= '0;
      ones_sb_q <= '0;
    end else begin
      len_q     <= len_d;
      total_q   <= total_d;
      ones_sb_q <= ones_sb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    k_q      <= k_d;
    zeros_q  <= zeros_d;
    is_sel_q <= is_sel_d;
    answer_q <= answer_d;
    found_q  <= found_d;
    error_q  <= error_d;
  end

  assign answer_o = answer_q;
  assign found_o  = found_q;
  assign error_o  = error_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q <= len_q) && (len_q <= CntW'(MaxBits)))
    else $error("Stored one count or length is out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sel_eval |-> (lo_q < hi_q) && (x_q < hi_q))
    else $error("Search probe lies outside the open interval.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rank_eval |-> (x_q <= len_q))
    else $error("Rank was evaluated beyond the stored length.");

endmodule

// ----- sim/tb_bitvector_rank_select.sv -----
`timescale 1ns / 1ps

module tb_bitvector_rank_select import bvrs_pkg::*; ();

  localparam logic [FuncW-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FuncW-1:0] FN_SPARE7 = 3'd7;
  localparam logic [9:0] KnownVector = 10'b1011000111;
  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 40;
  localparam int RandomPerPhase = 500;

  typedef struct {
    logic [FuncW-1:0] func;
    logic [CntW-1:0]  query;
    logic [CntW-1:0]  answer;
    logic             found;
    logic             error;
  } rs_answer_t;

  class rank_select_scoreboard;
    int unsigned ones_upto[MaxBits+1];
    int unsigned length;
    int unsigned fails;
    rs_answer_t  expected_answers[$];

    function new();
      length = 0;
      fails = 0;
      ones_upto[0] = 0;
    endfunction

    function int unsigned count_of(int unsigned x, bit zeros);
      return zeros ? x - ones_upto[x] : ones_upto[x];
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 100) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    function void note_request(logic [FuncW-1:0] f, logic b, logic [CntW-1:0] q);
      rs_answer_t  e;
      bit          zeros;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      e.func = f;
      e.query = q;
      e.answer = '0;
      e.found = 1'b0;
      e.error = 1'b0;
      zeros = (f == FN_RANK0) || (f == FN_SELECT0);
      case (f)
        FN_CLEAR: begin
          length = 0;
        end
        FN_APPEND: begin
          if (length >= MaxBits) begin
            e.error = 1'b1;
          end else begin
            ones_upto[length+1] = ones_upto[length] + b;
            length++;
          end
          e.answer = CntW'(length);
        end
        FN_RANK1, FN_RANK0: begin
          if (q > length) begin
            e.error = 1'b1;
          end else begin
            e.answer = CntW'(count_of(q, zeros));
          end
        end
        FN_SELECT1, FN_SELECT0: begin
          if (q == 0 || q > length) begin
            e.error = 1'b1;
          end else if (count_of(length, zeros) >= q) begin
            lo = 1;
            hi = length;
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (count_of(mid, zeros) >= q) begin
                hi = mid;
              end else begin
                lo = mid + 1;
              end
            end
            e.answer = CntW'(lo);
            e.found = 1'b1;
          end
        end
        default: begin
          e.error = 1'b1;
        end
      endcase
      expected_answers = {expected_answers, e};
    endfunction

    task check_answer(logic [CntW-1:0] a, logic fnd, logic err);
      rs_answer_t e;
      if (expected_answers.size() == 0) begin
        report($sformatf("result answer=%0d found=%b error=%b with no request pending",
                         a, fnd, err));
        return;
      end
      e = expected_answers.pop_front();
      if (a !== e.answer || fnd !== e.found || err !== e.error) begin
        report($sformatf("func=%0d query=%0d: answer %0d/%0d found %b/%b error %b/%b (got/exp)",
                         e.func, e.query, a, e.answer, fnd, e.found, err, e.error));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [FuncW-1:0] func_i = '0;
  logic             bit_value_i = 1'b0;
  logic [CntW-1:0]  query_value_i = '0;
  logic             done_o;
  logic [CntW-1:0]  answer_o;
  logic             found_o;
  logic             error_o;

  rank_select_scoreboard sb = new();
  int unsigned idle_pct;
  int unsigned cycle_count = 0;

  bitvector_rank_select i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .func_i,
    .bit_value_i,
    .query_value_i,
    .done_o,
    .answer_o,
    .found_o,
    .error_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      sb.check_answer(answer_o, found_o, error_o);
    end
  end

  task automatic send_request(logic [FuncW-1:0] f, logic b, logic [CntW-1:0] q);
    int unsigned gap;
    start_i <= 1'b1;
    func_i <= f;
    bit_value_i <= b;
    query_value_i <= q;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_request(f, b, q);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_request();
    int unsigned      r;
    int unsigned      k;
    int unsigned      total;
    logic [FuncW-1:0] f;
    logic             b;
    logic [CntW-1:0]  q;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 19);
    b = 1'($urandom_range(0, 1));
    q = CntW'($urandom_range(0, 8191));
    if (r < 2) begin
      f = FN_CLEAR;
    end else if (r < 4) begin
      f = $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;
    end else if (r < 50) begin
      f = FN_APPEND;
    end else if (r < 70) begin
      f = $urandom_range(0, 1) ? FN_RANK1 : FN_RANK0;
      if (k == 1) begin
        q = CntW'(sb.length + $urandom_range(1, 3));
      end else if (k > 1) begin
        q = CntW'($urandom_range(0, sb.length));
      end
    end else begin
      f = $urandom_range(0, 1) ? FN_SELECT1 : FN_SELECT0;
      total = sb.count_of(sb.length, f == FN_SELECT0);
      if (k == 1) begin
        q = '0;
      end else if (k == 2) begin
        q = CntW'(sb.length + 1);
      end else if ((k == 3 || k == 4) && total < sb.length) begin
        q = CntW'($urandom_range(total + 1, sb.length));
      end else if (k > 2) begin
        q = CntW'((total == 0) ? 1 : $urandom_range(1, total));
      end
    end
    send_request(f, b, q);
  endtask

  initial begin
    idle_pct = 14;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store, then a short known vector 1011000111.
    send_request(FN_CLEAR, 1'b0, '0);
    send_request(FN_RANK1, 1'b0, 13'd0);
    send_request(FN_RANK0, 1'b0, 13'd1);
    send_request(FN_SELECT1, 1'b0, 13'd1);
    send_request(FN_SELECT0, 1'b0, 13'd0);
    for (int i = 0; i < 10; i++) begin
      send_request(FN_APPEND, KnownVector[9-i], 13'h1FFF);
    end
    send_request(FN_RANK1, 1'b0, 13'd10);
    send_request(FN_RANK0, 1'b0, 13'd10);
    send_request(FN_RANK1, 1'b0, 13'd11);
    send_request(FN_SELECT1, 1'b0, 13'd6);
    send_request(FN_SELECT1, 1'b0, 13'd7);
    send_request(FN_SELECT0, 1'b0, 13'd4);
    send_request(FN_SELECT0, 1'b0, 13'd5);
    send_request(FN_SELECT1, 1'b0, 13'd11);
    send_request(FN_SPARE6, 1'b1, 13'h1FFF);
    send_request(FN_SPARE7, 1'b0, 13'd4096);
    send_request(FN_RANK1, 1'b1, 13'h1FFF);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 50 : 0;
      for (int n = 0; n < RandomPerPhase; n++) begin
        random_request();
      end
    end

    start_i <= 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
